### rtl/fp16_fp8_quantize_unit_defines.svh
// Assertion macros for the fp16 to fp8 quantizer.
`ifndef FP16_FP8_QUANTIZE_UNIT_DEFINES_SVH
`define FP16_FP8_QUANTIZE_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define FPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/fpq_pkg.sv
// Package for the fp16 to fp8 quantizer: mode codes and conversion functions.
`default_nettype none

package fpq_pkg;

   localparam logic [2:0] MODE_BF8      = 3'd0;
   localparam logic [2:0] MODE_HF8      = 3'd1;
   localparam logic [2:0] MODE_HF8_EXT  = 3'd2;
   localparam logic [2:0] MODE_E4M3     = 3'd3;
   localparam logic [2:0] MODE_HF8_B12  = 3'd4;

   localparam logic CSR_FORMAT_MODE     = 1'b0;
   localparam logic CSR_CLAMP_OVERFLOW  = 1'b1;

   // bf8 (1-5-2), round to nearest even, no rounding into infinity
   function automatic logic [15:0] quant_bf8(input logic [15:0] h);
      logic        special;
      logic [15:0] hv;
      begin
         special = &h[14:10];
         hv      = h;
         if (special && (h[9:0] != 10'd0)) begin
            hv = {h[15:8], 8'h00} | 16'h0200;
         end else begin
            if (!special && (h[14:8] < 7'h7B)) begin
               if ((h[7:0] > 8'h80) || (h[8:7] == 2'b11)) begin
                  hv = h + 16'h0100;
               end
            end
            hv = {hv[15:8], 8'h00};
         end
         return hv;
      end
   endfunction

   // hf8 (1-4-3) emulation; exponents are biased by 15
   function automatic logic [15:0] quant_hf8(input logic [15:0] h,
                                             input logic [4:0]  emax,
                                             input logic [9:0]  cmant,
                                             input logic [14:0] flush_lim,
                                             input logic [14:0] round_lim,
                                             input logic [4:0]  emin,
                                             input logic [4:0]  edge_exp,
                                             input logic        cap,
                                             input logic        clamp);
      logic [15:0] hv;
      logic [4:0]  eb;
      logic [4:0]  diff;
      logic [3:0]  shift;
      logic [10:0] mant;
      logic [10:0] keep;
      logic [15:0] sum;
      logic        sign;
      logic        rnd_ok;
      logic        special;
      begin
         hv      = (h[14:0] < flush_lim) ? 16'h0000 : h;
         eb      = hv[14:10];
         sign    = hv[15];
         mant    = {1'b0, hv[9:0]};
         rnd_ok  = hv[14:0] < round_lim;
         special = &hv[14:10];
         shift   = 4'd0;
         if (eb > emax) begin
            if (clamp) begin
               eb   = emax;
               mant = {1'b0, cmant};
            end else begin
               eb      = 5'h1F;
               mant    = 11'd0;
               special = 1'b1;
            end
         end else if (eb < emin) begin
            eb   = 5'd0;
            mant = 11'd0;
         end
         if (cap && (eb == emax) && (mant > {1'b0, cmant})) begin
            mant = {1'b0, cmant};
         end
         if (!special && rnd_ok) begin
            if ((mant[6:0] > 7'h40) || (mant[7:6] == 2'b11)) begin
               mant = mant + 11'h080;
            end
         end
         if (eb < edge_exp) begin
            diff  = edge_exp - eb;
            shift = {1'b0, diff[2:0]};
         end
         keep = 11'h7FF << (4'd7 + shift);
         mant = mant & keep;
         sum  = {1'b0, eb, 10'd0} + {5'd0, mant};
         return sum | {sign, 15'd0};
      end
   endfunction

   // exact E4M3 encode (bias 7), overflow and NaN give s|0x7F
   function automatic logic [7:0] e4m3_encode(input logic [15:0] h);
      logic [4:0]  ef;
      logic [9:0]  mf;
      logic [3:0]  sh;
      logic [10:0] mt;
      logic [15:0] r;
      logic [4:0]  er;
      logic [6:0]  body;
      begin
         ef = h[14:10];
         mf = h[9:0];
         sh = 4'd0;
         mt = 11'd0;
         r  = 16'd0;
         er = 5'd0;
         if ((ef == 5'h1F) || (ef > 5'd23) || ((ef == 5'd23) && (mf > 10'h300))) begin
            body = 7'h7F;
         end else if (ef < 5'd5) begin
            body = 7'h00;
         end else if (ef <= 5'd8) begin
            sh   = 4'd9 - ef[3:0];
            mt   = {1'b1, mf} >> sh;
            mt   = mt | {10'd0, |mf[6:0]};
            mt   = mt + 11'h03F + {10'd0, mt[7]};
            body = {3'd0, mt[10:7]};
         end else begin
            r    = h + 16'h003F + {15'd0, mf[7]};
            er   = r[14:10] - 5'd8;
            body = {er[3:0], r[9:7]};
         end
         return {h[15], body};
      end
   endfunction

   // E4M3 byte back to fp16 bits
   function automatic logic [15:0] e4m3_decode(input logic [7:0] b);
      logic [3:0] e;
      logic [2:0] m;
      logic [4:0] en;
      logic [1:0] lz;
      logic [5:0] ms;
      begin
         e  = b[6:3];
         m  = b[2:0];
         en = {1'b0, e} + 5'd8;
         lz = 2'd0;
         ms = 6'd0;
         if ((e == 4'hF) && (m == 3'h7)) begin
            return {b[7], 15'h7E00};
         end
         if (e == 4'd0) begin
            if (m == 3'd0) begin
               return {b[7], 15'd0};
            end
            lz = (m > 3'd3) ? 2'd0 : ((m > 3'd1) ? 2'd1 : 2'd2);
            en = en - {3'd0, lz};
            ms = {3'd0, m} << ({1'b0, lz} + 3'd1);
            m  = ms[2:0];
         end
         return {b[7], en, m, 7'd0};
      end
   endfunction

endpackage

`default_nettype wire

### rtl/fp16_fp8_quantize_unit.sv
// An accepted req word passes the input register, then the result register, on its way to rsp.
// One word per cycle unless rsp stalls; all conversion logic sits between the two registers.
// A stalled result does not block intake while the input register is free.
// Reset (synchronous, active high) empties both registers; format_mode resets to bf8,
// clamp_overflow to 1.
`default_nettype none

`include "fp16_fp8_quantize_unit_defines.svh"

module fp16_fp8_quantize_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] half_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [15:0] half_out, [23:16] fp8_code
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [2:0]  csr_wdata
);

   logic [2:0]  mode_ff, mode_in;
   logic        clamp_ff, clamp_in;
   logic        in_valid_ff, in_valid_in;
   logic [15:0] half_ff, half_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] res_ff, res_in;
   logic [7:0]  code_ff, code_in;
   logic        out_adv;
   logic        req_acc;

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {code_ff, res_ff};

   always_comb begin
      mode_in  = mode_ff;
      clamp_in = clamp_ff;
      if (csr_we) begin
         unique case (csr_index)
            fpq_pkg::CSR_FORMAT_MODE:    mode_in  = csr_wdata;
            fpq_pkg::CSR_CLAMP_OVERFLOW: clamp_in = csr_wdata[0];
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      half_in     = half_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (req_acc) begin
         half_in = req_tdata;
      end
   end

   // conversion
   always_comb begin
      logic [15:0] res;
      logic [7:0]  code;
      res  = half_ff;
      code = 8'd0;
      unique case (mode_ff)
         fpq_pkg::MODE_BF8: res = fpq_pkg::quant_bf8(half_ff);
         fpq_pkg::MODE_HF8:
            res = fpq_pkg::quant_hf8(half_ff, 5'd18, 10'h380, 15'h0800, 15'h4B80,
                                     5'd2, 5'd5, 1'b0, clamp_ff);
         fpq_pkg::MODE_HF8_EXT:
            res = fpq_pkg::quant_hf8(half_ff, 5'd19, 10'h300, 15'h0800, 15'h4B80,
                                     5'd2, 5'd5, 1'b1, clamp_ff);
         fpq_pkg::MODE_E4M3: begin
            code = fpq_pkg::e4m3_encode(half_ff);
            res  = fpq_pkg::e4m3_decode(code);
         end
         fpq_pkg::MODE_HF8_B12:
            res = fpq_pkg::quant_hf8(half_ff, 5'd17, 10'h380, 15'h0400, 15'h4780,
                                     5'd1, 5'd4, 1'b0, clamp_ff);
         default: res = half_ff;
      endcase
      res_in  = res_ff;
      code_in = code_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_adv) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            res_in  = res;
            code_in = code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= fpq_pkg::MODE_BF8;
         clamp_ff     <= 1'b1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         clamp_ff     <= clamp_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= half_in;
      res_ff  <= res_in;
      code_ff <= code_in;
   end

   `FPQ_ASSERT(a_accept_fills_input, req_acc |=> in_valid_ff, "accepted word not held")
   `FPQ_ASSERT(a_input_moves_out, (in_valid_ff && out_adv) |=> rsp_tvalid, "input word lost")
   `FPQ_ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_tvalid && !in_valid_ff), "not empty")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for fp16_fp8_quantize_unit: directed and random fp16 words vs. a predictor.
`timescale 1ns / 1ps

module tb;

   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int         CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [15:0] half;
      logic [7:0]  code;
   } quant_word_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        clip;
      logic [15:0] value;
   } directed_type;

   localparam directed_type DIRECTED [25] = '{
      '{fpq_pkg::MODE_BF8, 1'b1, 16'h7E01}, '{fpq_pkg::MODE_BF8, 1'b1, 16'hFC00},
      '{fpq_pkg::MODE_BF8, 1'b1, 16'h7BFF}, '{fpq_pkg::MODE_BF8, 1'b1, 16'h3D80},
      '{fpq_pkg::MODE_BF8, 1'b1, 16'h0000}, '{fpq_pkg::MODE_BF8, 1'b1, 16'hFFFF},
      '{fpq_pkg::MODE_BF8, 1'b1, 16'h3C81},
      '{fpq_pkg::MODE_HF8, 1'b1, 16'h8001}, '{fpq_pkg::MODE_HF8, 1'b1, 16'h7C00},
      '{fpq_pkg::MODE_HF8, 1'b1, 16'hCC00},
      '{fpq_pkg::MODE_HF8, 1'b0, 16'h5000}, '{fpq_pkg::MODE_HF8, 1'b0, 16'h7E00},
      '{fpq_pkg::MODE_HF8_EXT, 1'b1, 16'h4FFF}, '{fpq_pkg::MODE_HF8_EXT, 1'b1, 16'h0800},
      '{fpq_pkg::MODE_HF8_B12, 1'b1, 16'h03FF}, '{fpq_pkg::MODE_HF8_B12, 1'b1, 16'h4780},
      '{fpq_pkg::MODE_HF8_B12, 1'b1, 16'h0400},
      '{fpq_pkg::MODE_HF8_B12, 1'b0, 16'hC800},
      '{fpq_pkg::MODE_E4M3, 1'b1, 16'h5F01}, '{fpq_pkg::MODE_E4M3, 1'b1, 16'h5F00},
      '{fpq_pkg::MODE_E4M3, 1'b1, 16'h7C00}, '{fpq_pkg::MODE_E4M3, 1'b1, 16'h0FFF},
      '{fpq_pkg::MODE_E4M3, 1'b1, 16'h9400}, '{fpq_pkg::MODE_E4M3, 1'b1, 16'h2000},
      '{MODE_SPARE_HI, 1'b1, 16'h1234}
   };

   localparam logic [2:0] PHASE_MODE [10] = '{
      fpq_pkg::MODE_BF8, fpq_pkg::MODE_HF8, fpq_pkg::MODE_HF8,
      fpq_pkg::MODE_HF8_EXT, fpq_pkg::MODE_HF8_EXT, fpq_pkg::MODE_E4M3,
      fpq_pkg::MODE_HF8_B12, fpq_pkg::MODE_HF8_B12, MODE_SPARE_LO, MODE_SPARE_HI
   };

   localparam logic [7:0] TIE_BITS [8] = '{
      8'h40, 8'h3F, 8'h41, 8'h7F, 8'h80, 8'h81, 8'hC0, 8'hFF
   };

   class quant_scoreboard;
      logic [2:0]     mode;
      bit             clamp;
      quant_word_type expected_q[$];
      int             errors;

      function new();
         mode   = fpq_pkg::MODE_BF8;
         clamp  = 1'b1;
         errors = 0;
      endfunction

      function logic [15:0] bf8_round(input logic [15:0] h);
         logic        special;
         logic [15:0] v;
         special = (h[14:10] == 5'h1F);
         if (special && (h[9:0] != 10'd0))
            return {h[15:8], 8'h00} | 16'h0200;
         v = h;
         if (!special && ((h & 16'h7F00) < 16'h7B00)) begin
            if ((h[7:0] > 8'h80) || (h[8:7] == 2'b11))
               v = h + 16'h0100;
         end
         return v & 16'hFF00;
      endfunction

      function logic [15:0] hf8_round(input logic [15:0] hin, input int emax,
                                      input int unsigned cmant, input int unsigned flush_lim,
                                      input int unsigned round_lim, input int emin,
                                      input int edge_e, input bit cap, input bit clip);
         int unsigned h, sign, mant, shift;
         int          e;
         bit          rnd_ok, special;
         h     = hin;
         shift = 0;
         if ((h & 'h7FFF) < flush_lim)
            h = 0;
         e       = int'((h >> 10) & 'h1F) - 15;
         sign    = h & 'h8000;
         mant    = h & 'h3FF;
         rnd_ok  = (h & 'h7FFF) < round_lim;
         special = (h & 'h7C00) == 'h7C00;
         if (e > emax) begin
            if (clip) begin
               e    = emax;
               mant = cmant;
            end else begin
               e       = 16;
               mant    = 0;
               special = 1'b1;
            end
         end else if (e < emin) begin
            e    = -15;
            mant = 0;
         end
         if (cap && (e == emax) && (mant > cmant))
            mant = cmant;
         if (!special && rnd_ok) begin
            if (((mant & 'h7F) > 'h40) || ((mant & 'hC0) == 'hC0))
               mant += 'h80;
         end
         if (e < edge_e) begin
            shift = edge_e - e;
            mant  = mant >> shift;
         end
         mant = mant & 'hFF80;
         mant = mant << shift;
         mant = mant + ((e + 15) << 10);
         return 16'((mant | sign) & 'hFFFF);
      endfunction

      function logic [7:0] e4m3_pack(input logic [15:0] h);
         int unsigned s, ef, mf, e, m, r;
         s  = h[15] ? 'h80 : 0;
         ef = h[14:10];
         mf = h[9:0];
         if ((ef == 'h1F) || (ef > 23) || ((ef == 23) && (mf > 'h300))) begin
            e = 'hF;
            m = 'h7;
         end else if (ef < 5) begin
            e = 0;
            m = 0;
         end else if (ef <= 8) begin
            m = (mf | 'h400) >> (9 - ef);
            m = m | (((mf & 'h7F) + 'h7F) >> 7);
            m = m + 'h3F + ((m >> 7) & 1);
            m = m >> 7;
            e = 0;
         end else begin
            r = (h + 'h3F + ((mf >> 7) & 1)) & 'hFFFF;
            e = ((r >> 10) & 'h1F) - 8;
            m = (r & 'h3FF) >> 7;
         end
         return 8'((s | ((e << 3) + m)) & 'hFF);
      endfunction

      function logic [15:0] e4m3_unpack(input logic [7:0] b);
         int unsigned s, e, m, en, lz;
         s  = b[7] ? 'h8000 : 0;
         e  = b[6:3];
         m  = b[2:0];
         en = e + 8;
         if ((e == 'hF) && (m == 'h7))
            return 16'(s | 'h7E00);
         if (e == 0) begin
            if (m == 0)
               return 16'(s);
            lz = (m > 3) ? 0 : ((m > 1) ? 1 : 2);
            en = en - lz;
            m  = (m << (lz + 1)) & 'h7;
         end
         return 16'((s | (en << 10) | (m << 7)) & 'hFFFF);
      endfunction

      function quant_word_type quantize(input logic [15:0] h);
         quant_word_type w;
         w.half = h;
         w.code = 8'h00;
         case (mode)
            fpq_pkg::MODE_BF8: w.half = bf8_round(h);
            fpq_pkg::MODE_HF8:
               w.half = hf8_round(h, 3, 'h380, 'h800, 'h4B80, -13, -10, 1'b0, clamp);
            fpq_pkg::MODE_HF8_EXT:
               w.half = hf8_round(h, 4, 'h300, 'h800, 'h4B80, -13, -10, 1'b1, clamp);
            fpq_pkg::MODE_E4M3: begin
               w.code = e4m3_pack(h);
               w.half = e4m3_unpack(w.code);
            end
            fpq_pkg::MODE_HF8_B12:
               w.half = hf8_round(h, 2, 'h380, 'h400, 'h4780, -14, -11, 1'b0, clamp);
            default: ;
         endcase
         return w;
      endfunction

      function void note_input(input logic [15:0] h);
         expected_q.push_back(quantize(h));
      endfunction

      function void check_result(input logic [15:0] half, input logic [7:0] code);
         quant_word_type w;
         if (expected_q.size() == 0) begin
            $error("unexpected rsp word: half_out %h, fp8_code %h", half, code);
            errors++;
            return;
         end
         w = expected_q.pop_front();
         if (half !== w.half) begin
            $error("half_out: expected %h, got %h", w.half, half);
            errors++;
         end
         if (code !== w.code) begin
            $error("fp8_code: expected %h, got %h", w.code, code);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // [15:0] half_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;               // [15:0] half_out, [23:16] fp8_code
   logic        csr_we     = 1'b0;
   logic        csr_index  = fpq_pkg::CSR_FORMAT_MODE;
   logic [2:0]  csr_wdata  = 3'd0;

   quant_scoreboard sb;
   int              req_run     = 0;
   int              rsp_run     = 0;
   int              cycle_count = 0;

   fp16_fp8_quantize_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // random idle runs, with occasional stretches of back-to-back words
   function automatic int idle_draw(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         run_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   task automatic send_word(input logic [15:0] value);
      int gap;
      gap = idle_draw(req_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_input(value);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [2:0] mode, input logic clip);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= fpq_pkg::CSR_FORMAT_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      csr_index <= fpq_pkg::CSR_CLAMP_OVERFLOW;
      csr_wdata <= {2'b00, clip};
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.mode  = mode;
      sb.clamp = clip;
   endtask

   initial begin : rsp_side
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_draw(rsp_run);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata[15:0], rsp_tdata[23:16]);
      end
   end

   initial begin : stimulus
      logic [15:0] v;
      logic [2:0]  mode;
      logic        clip;
      int          count;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // first group runs on the reset settings
      foreach (DIRECTED[i]) begin
         if ((DIRECTED[i].mode != sb.mode) || (DIRECTED[i].clip != sb.clamp))
            apply_setting(DIRECTED[i].mode, DIRECTED[i].clip);
         send_word(DIRECTED[i].value);
      end

      for (int p = 0; p < 14; p++) begin
         if (p < 10) begin
            mode = PHASE_MODE[p];
            clip = p[0];
         end else begin
            mode = 3'($urandom_range(fpq_pkg::MODE_BF8, fpq_pkg::MODE_HF8_B12));
            clip = 1'($urandom);
         end
         apply_setting(mode, clip);
         count = (mode > fpq_pkg::MODE_HF8_B12) ? 12 : 55;
         repeat (count) begin
            case ($urandom_range(0, 3))
               0: v = 16'($urandom);
               1: v = {1'($urandom), 5'($urandom), 2'($urandom), TIE_BITS[$urandom_range(0, 7)]};
               2: v = {1'($urandom), 5'($urandom_range(17, 23)), 10'($urandom)};
               default: v = {1'($urandom), 5'($urandom_range(0, 10)), 10'($urandom)};
            endcase
            send_word(v);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if ((sb.errors == 0) && (sb.pending() == 0))
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### fp16_fp8_quantize_unit.f
+incdir+rtl
rtl/fpq_pkg.sv
rtl/fp16_fp8_quantize_unit.sv
tb/tb.sv
